/* rtl/bos_pkg.sv */
// shared types and constants for the box overlap suppression block
package bos_pkg;

    localparam int COORD_W   = 16;
    localparam int SLOT_W    = 6;
    localparam int RIGHT_W   = COORD_W + 1;
    localparam int EXT_W     = COORD_W + 2;
    localparam int AREA_W    = 2 * (EXT_W - 1);
    localparam int THR_W     = 32;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 8;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;

    localparam logic [THR_W-1:0] THR_RESET = 32'd1000;

    // x sits in the lowest bits, matching the input packing
    typedef struct packed {
        logic signed [COORD_W-1:0] h;
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } box_t;

    typedef struct packed {
        logic              last;
        logic              alive;
        logic [SLOT_W-1:0] slot;
        box_t              box;
    } q_entry_t;

endpackage

/* rtl/bos_ram.sv */
// generic single-write, single-read ram with registered read data
module bos_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bos_front.sv */
// input side: accepts boxes, assigns slots and marks the end of each set
module bos_front #(
    parameter int MAX_BOXES = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bos_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    input  logic                         q_full,
    output logic                         q_push,
    output bos_pkg::q_entry_t            q_entry
);
    import bos_pkg::*;

    localparam int IDX_W = $clog2(MAX_BOXES);

    logic [IDX_W-1:0] cnt_reg;
    logic             set_end;

    // a full store closes the set just like tlast
    assign set_end  = s_tlast || (cnt_reg == IDX_W'(MAX_BOXES - 1));
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign q_entry.box   = box_t'(s_tdata[4*COORD_W-1:0]);
    assign q_entry.alive = s_tdata[4*COORD_W];
    assign q_entry.slot  = SLOT_W'(cnt_reg);
    assign q_entry.last  = set_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (q_push) begin
            cnt_reg <= set_end ? '0 : cnt_reg + IDX_W'(1);
        end
    end

endmodule

/* rtl/bos_queue.sv */
// short fifo between the input side and the suppression engine
module bos_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bos_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output bos_pkg::q_entry_t pop_entry,
    output logic              not_empty
);
    import bos_pkg::*;

    q_entry_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   cnt_reg;

    assign full      = (cnt_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + (Q_PTR_W + 1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (Q_PTR_W + 1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

/* rtl/bos_engine.sv */
// back end: stores a set, runs the pairwise suppression and emits keep flags
module bos_engine #(
    parameter int MAX_BOXES = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [bos_pkg::THR_W-1:0]    threshold,
    input  logic                         q_valid,
    input  bos_pkg::q_entry_t            q_entry,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bos_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import bos_pkg::*;

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_FIND  = 3'd1;
    localparam logic [2:0] ST_LDI   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]           state_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     i_reg;
    logic [CNT_W-1:0]     j_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [MAX_BOXES-1:0] alive_reg;

    // pair pipeline
    logic                       rd_v, e1_v, e2_v, mul_v;
    logic [IDX_W-1:0]           j_rd_reg, j_e1_reg, j_e2_reg, j_mul_reg;
    box_t                       bi_reg;
    logic signed [RIGHT_W-1:0]  bi_rx_reg, bi_ry_reg;
    logic signed [COORD_W-1:0]  lo_x_reg, lo_y_reg;
    logic signed [RIGHT_W-1:0]  rx_reg, ry_reg;
    logic [EXT_W-2:0]           ex_reg, ey_reg;
    logic [AREA_W-1:0]          prod_reg;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;

    logic [IDX_W-1:0]          raddr;
    logic [4*COORD_W-1:0]      rd_data;
    box_t                      bj;
    box_t                      bi_rd;
    logic                      pipe_busy;
    logic                      out_load;
    logic                      k_last;
    logic                      hit;
    logic signed [RIGHT_W-1:0] min_x, min_y;
    logic signed [EXT_W-1:0]   ext_x, ext_y;
    logic                      overlap;

    assign q_pop     = (state_reg == ST_LOAD) && q_valid;
    assign raddr     = (state_reg == ST_FIND) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
    assign pipe_busy = rd_v | e1_v | e2_v | mul_v;
    assign out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);
    assign k_last    = ((k_reg + CNT_W'(1)) == n_reg);

    bos_ram #(
        .WIDTH (4 * COORD_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .aclk  (aclk),
        .we    (q_pop),
        .waddr (q_entry.slot[IDX_W-1:0]),
        .wdata (q_entry.box),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign bj    = box_t'(rd_data);
    assign bi_rd = box_t'(rd_data);

    // second extent stage: smaller right edge minus larger left edge
    always_comb begin
        min_x   = (bi_rx_reg < rx_reg) ? bi_rx_reg : rx_reg;
        min_y   = (bi_ry_reg < ry_reg) ? bi_ry_reg : ry_reg;
        ext_x   = {min_x[RIGHT_W-1], min_x} - {{2{lo_x_reg[COORD_W-1]}}, lo_x_reg};
        ext_y   = {min_y[RIGHT_W-1], min_y} - {{2{lo_y_reg[COORD_W-1]}}, lo_y_reg};
        overlap = !ext_x[EXT_W-1] && (ext_x != '0) && !ext_y[EXT_W-1] && (ext_y != '0);
    end

    assign hit = mul_v && (prod_reg >= AREA_W'(threshold));

    always_ff @(posedge aclk) begin
        j_rd_reg  <= j_reg[IDX_W-1:0];
        j_e1_reg  <= j_rd_reg;
        j_e2_reg  <= j_e1_reg;
        j_mul_reg <= j_e2_reg;
        if (state_reg == ST_LDI) begin
            bi_reg    <= bi_rd;
            bi_rx_reg <= RIGHT_W'(bi_rd.x) + RIGHT_W'(bi_rd.w);
            bi_ry_reg <= RIGHT_W'(bi_rd.y) + RIGHT_W'(bi_rd.h);
        end
        lo_x_reg <= (bi_reg.x > bj.x) ? bi_reg.x : bj.x;
        lo_y_reg <= (bi_reg.y > bj.y) ? bi_reg.y : bj.y;
        rx_reg   <= RIGHT_W'(bj.x) + RIGHT_W'(bj.w);
        ry_reg   <= RIGHT_W'(bj.y) + RIGHT_W'(bj.h);
        ex_reg   <= overlap ? ext_x[EXT_W-2:0] : '0;
        ey_reg   <= overlap ? ext_y[EXT_W-2:0] : '0;
        prod_reg <= AREA_W'(ex_reg) * AREA_W'(ey_reg);
        if (out_load) begin
            m_data_reg <= {1'b0, alive_reg[k_reg[IDX_W-1:0]], SLOT_W'(k_reg)};
            m_last_reg <= k_last;
        end
    end

    // alive flags are written at load, so they need no reset
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            alive_reg[q_entry.slot[IDX_W-1:0]] <= q_entry.alive;
        end else if (hit) begin
            alive_reg[j_mul_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            n_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            rd_v        <= 1'b0;
            e1_v        <= 1'b0;
            e2_v        <= 1'b0;
            mul_v       <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_v  <= 1'b0;
            e1_v  <= rd_v;
            e2_v  <= e1_v;
            mul_v <= e2_v;
            case (state_reg)
                ST_LOAD: begin
                    if (q_valid && q_entry.last) begin
                        n_reg     <= CNT_W'(q_entry.slot) + CNT_W'(1);
                        i_reg     <= '0;
                        state_reg <= ST_FIND;
                    end
                end
                ST_FIND: begin
                    if (i_reg == n_reg) begin
                        k_reg     <= '0;
                        state_reg <= ST_EMIT;
                    end else if (alive_reg[i_reg[IDX_W-1:0]]) begin
                        state_reg <= ST_LDI;
                    end else begin
                        i_reg <= i_reg + CNT_W'(1);
                    end
                end
                ST_LDI: begin
                    j_reg     <= i_reg + CNT_W'(1);
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (j_reg == n_reg) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        rd_v  <= 1'b1;
                        j_reg <= j_reg + CNT_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!pipe_busy) begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= ST_FIND;
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        k_reg <= k_reg + CNT_W'(1);
                        if (k_last) begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_full_store_ends_set : assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_entry.last) |-> (q_entry.slot != SLOT_W'(MAX_BOXES - 1)))
        else $error("box in final slot did not close the set");

    a_scan_after_i : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (j_reg > i_reg))
        else $error("pair scan index not above the suppressing box");

    a_emit_after_drain : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !pipe_busy)
        else $error("results emitted with pair checks still in flight");

endmodule

/* rtl/box_overlap_suppression.sv */
// top level of the greedy box overlap suppression block
// items enter at one per cycle while the four-entry queue has room
// per set of n boxes: the boxes are loaded, then each live box i is checked against each later
// box (a dead box is skipped), then n results are emitted; all pair checks go through the single
// pair pipeline on the box ram's one read port
// synchronous active-low reset clears control state and sets the threshold to 1000
module box_overlap_suppression #(
    parameter int MAX_BOXES = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration: overlap threshold
    input  logic                         cfg_we,
    input  logic [bos_pkg::THR_W-1:0]    cfg_wdata,
    // box input
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // fields from bit 0: left_x[15:0], top_y[31:16], box_width[47:32],
    // box_height[63:48], alive_in[64], zero fill[71:65]
    input  logic [bos_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    // result output
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // fields from bit 0: box_index[5:0], keep[6], zero fill[7]
    output logic [bos_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import bos_pkg::*;

    logic [THR_W-1:0] thr_reg;

    // queue between the two halves
    logic     q_push;
    logic     q_full;
    q_entry_t q_push_entry;
    logic     q_pop;
    logic     q_not_empty;
    q_entry_t q_head;

    // threshold register; the user must write it only while the block is idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // front: numbers each box within its set and flags the end of the set
    bos_front #(
        .MAX_BOXES (MAX_BOXES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    // lets up to four boxes of the next set queue up while the engine is still busy
    bos_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_head),
        .not_empty  (q_not_empty)
    );

    // back: box store, suppression sweep and registered result output
    bos_engine #(
        .MAX_BOXES (MAX_BOXES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .threshold (thr_reg),
        .q_valid   (q_not_empty),
        .q_entry   (q_head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* bench/box_overlap_suppression_test.sv */
// self-checking testbench for the box overlap suppression block
`timescale 1ns / 1ps

module box_overlap_suppression_test;

    import bos_pkg::*;

    localparam int  MAX_BOXES    = 32;
    localparam int  SETTLE_CYCLES = 64;    // quiet time before touching the threshold
    localparam int  TAIL_CYCLES   = 200;   // drain time once the last result is in
    localparam int  HOLD_CYCLES   = 1500;  // long receiver hold-off for the pressure test
    localparam int  MAX_REPORTS   = 10;

    // one expected result: box position, keep flag, end-of-set marker
    typedef struct packed {
        logic              last;
        logic              keep;
        logic [SLOT_W-1:0] idx;
    } verdict_t;

    // clock, reset and block ports; the ones the bench drives are known from time zero
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [THR_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    // behaviour of both ends
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    logic hold_req   = 1'b0;
    int   hold_left  = 0;

    // predictor state: boxes of the set being loaded and their live flags
    box_t         boxes_held [MAX_BOXES];
    bit           live_flags [MAX_BOXES];
    int           boxes_loaded;
    logic [31:0]  thr_model;

    verdict_t     pending_verdicts [$];
    int           error_count = 0;
    int           items_sent  = 0;

    box_overlap_suppression #(
        .MAX_BOXES (MAX_BOXES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // exact intersection area of two boxes, zero when either extent is not positive
    function automatic longint overlap_area_of(box_t a, box_t b);
        int ax, ay, aw, ah, bx, by, bw, bh;
        int lo_x, lo_y, hi_x, hi_y, ext_x, ext_y;
        ax = int'($signed(a.x));
        ay = int'($signed(a.y));
        aw = int'($signed(a.w));
        ah = int'($signed(a.h));
        bx = int'($signed(b.x));
        by = int'($signed(b.y));
        bw = int'($signed(b.w));
        bh = int'($signed(b.h));
        lo_x  = (ax > bx) ? ax : bx;
        lo_y  = (ay > by) ? ay : by;
        hi_x  = (ax + aw < bx + bw) ? ax + aw : bx + bw;
        hi_y  = (ay + ah < by + bh) ? ay + ah : by + bh;
        ext_x = hi_x - lo_x;
        ext_y = hi_y - lo_y;
        if (ext_x <= 0 || ext_y <= 0)
            return 0;
        return longint'(ext_x) * longint'(ext_y);
    endfunction

    // load one accepted box; at the end of a set run greedy suppression and
    // queue one verdict per stored box in load order
    task automatic predict_keep_flags(input box_t b, input bit alive, input bit last);
        int n;
        longint limit;
        boxes_held[boxes_loaded] = b;
        live_flags[boxes_loaded] = alive;
        n = boxes_loaded + 1;
        if (!last && n < MAX_BOXES) begin
            boxes_loaded = n;
            return;
        end
        // a full store ends the set even without the last marker
        limit = longint'(thr_model);
        for (int i = 0; i < n; i++) begin
            if (!live_flags[i])
                continue;
            for (int j = 0; j < n; j++) begin
                if (j == i || !live_flags[j])
                    continue;
                if (overlap_area_of(boxes_held[i], boxes_held[j]) >= limit)
                    live_flags[j] = 1'b0;
            end
        end
        for (int i = 0; i < n; i++)
            pending_verdicts.push_back('{last: (i == n - 1), keep: live_flags[i],
                                         idx: SLOT_W'(i)});
        boxes_loaded = 0;
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_req  <= 1'b0;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // result checker: each accepted result against the oldest verdict
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int want, input int got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what,
                     want, got);
    endtask

    always @(posedge aclk) begin : check_results
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                note_mismatch("unexpected result, box index", -1,
                              int'(m_tdata[SLOT_W-1:0]));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[SLOT_W-1:0] !== want.idx)
                    note_mismatch("box_index", int'(want.idx),
                                  int'(m_tdata[SLOT_W-1:0]));
                if (m_tdata[SLOT_W] !== want.keep)
                    note_mismatch("keep", int'(want.keep), int'(m_tdata[SLOT_W]));
                if (m_tlast !== want.last)
                    note_mismatch("last_result", int'(want.last), int'(m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers, all entered and left at a rising edge
    // ------------------------------------------------------------------

    function automatic box_t mk_box(input int x, input int y, input int w, input int h);
        box_t b;
        b.x = 16'(x);
        b.y = 16'(y);
        b.w = 16'(w);
        b.h = 16'(h);
        return b;
    endfunction

    // offer one item, with a random idle gap in front, until the block takes it
    task automatic send_box(input box_t b, input bit alive, input bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 65){1'b0}}, alive, b};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_keep_flags(b, alive, last);
        items_sent++;
    endtask

    // sender pauses until every outstanding verdict has been seen, then a quiet spell
    task automatic wait_for_all_results();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // only called with the block idle
    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        thr_model = value;
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1;
            3:       return $urandom;
            default: return $urandom_range(6000, 1);
        endcase
    endfunction

    // mostly boxes clustered round a centre so they overlap, some pure noise
    function automatic box_t random_box(input int cx, input int cy);
        box_t b;
        if ($urandom_range(99) < 15) begin
            b = {$urandom, $urandom};
        end else begin
            b.x = 16'(cx + int'($urandom_range(120)) - 60);
            b.y = 16'(cy + int'($urandom_range(120)) - 60);
            b.w = 16'($urandom_range(120, 1));
            b.h = 16'($urandom_range(120, 1));
            // the odd empty or inverted box
            if ($urandom_range(99) < 5)
                b.w = 16'(int'($urandom_range(40)) - 30);
            if ($urandom_range(99) < 5)
                b.h = 16'(int'($urandom_range(40)) - 30);
        end
        return b;
    endfunction

    // one set of n boxes; without the last marker only a full store ends it
    task automatic send_set(input int n, input bit mark_last);
        int cx, cy;
        cx = int'($urandom_range(65535)) - 32768;
        cy = int'($urandom_range(65535)) - 32768;
        for (int i = 0; i < n; i++)
            send_box(random_box(cx, cy), $urandom_range(99) < 85,
                     (i == n - 1) && mark_last);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset threshold of 1000: single box, exact-threshold overlap, dead box,
    // inverted box at the coordinate extremes
    task automatic test_reset_threshold();
        send_box(mk_box(-32768, -32768, 32767, 32767), 1'b1, 1'b1);
        send_box(mk_box(0, 0, 100, 100),               1'b1, 1'b0);
        send_box(mk_box(10, 10, 100, 100),             1'b1, 1'b0);  // 8100, suppressed
        send_box(mk_box(50, 0, 20, 50),                1'b1, 1'b0);  // exactly 1000
        send_box(mk_box(0, 0, 100, 100),               1'b0, 1'b0);  // dead, never kept
        send_box(mk_box(32767, 32767, -32768, -32768), 1'b1, 1'b1);
        wait_for_all_results();
    endtask

    // zero, all-ones and one as threshold
    task automatic test_threshold_extremes();
        // zero: first live box suppresses every other live one, even disjoint
        write_threshold('0);
        send_box(mk_box(100, 100, 10, 10),    1'b1, 1'b0);
        send_box(mk_box(-5000, -5000, 3, 3),  1'b1, 1'b0);
        send_box(mk_box(100, 100, 10, 10),    1'b0, 1'b0);
        send_box(mk_box(7, 7, -1, -32768),    1'b1, 1'b1);
        wait_for_all_results();
        // all ones: no area can reach it
        write_threshold('1);
        send_box(mk_box(-32768, -32768, 32767, 32767), 1'b1, 1'b0);
        send_box(mk_box(-32768, -32768, 32767, 32767), 1'b1, 1'b0);
        send_box(mk_box(-32767, -32767, 32767, 32767), 1'b1, 1'b1);
        wait_for_all_results();
        // one: a suppressed box no longer suppresses, touching edges do not overlap
        write_threshold(32'd1);
        send_box(mk_box(0, 0, 10, 10),   1'b1, 1'b0);
        send_box(mk_box(5, 5, 10, 10),   1'b1, 1'b0);
        send_box(mk_box(12, 12, 10, 10), 1'b1, 1'b0);
        send_box(mk_box(10, 0, 10, 10),  1'b1, 1'b1);
        wait_for_all_results();
    endtask

    // random sets, a fresh threshold for every group of sets
    task automatic test_random_sets(input int src_pct, input int snk_pct,
                                    input int n_items);
        int goal;
        int n;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            wait_for_all_results();
            write_threshold(pick_threshold());
            repeat ($urandom_range(3, 1)) begin
                if ($urandom_range(9) == 0)
                    n = $urandom_range(MAX_BOXES, 20);
                else
                    n = $urandom_range(10, 1);
                send_set(n, (n < MAX_BOXES) ? 1'b1 : 1'($urandom_range(1)));
            end
        end
        wait_for_all_results();
    endtask

    // full store: one set ends by filling the last slot, one with the marker there too
    task automatic test_store_full();
        write_threshold($urandom_range(4000, 200));
        send_set(MAX_BOXES, 1'b0);
        send_set(MAX_BOXES, 1'b1);
        wait_for_all_results();
    endtask

    // receiver holds off for a long stretch while items keep coming, so the
    // block fills and stalls its input; then the sender waits for everything
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_threshold(32'd500);
        hold_req <= 1'b1;
        repeat (3) send_set(8, 1'b1);
        wait_for_all_results();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        boxes_loaded = 0;
        thr_model    = THR_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        // sender idles now and then, receiver mostly stalls
        src_idle_pct = 18;
        snk_idle_pct = 81;
        test_reset_threshold();
        test_threshold_extremes();
        test_random_sets(18, 81, 80);
        // the other way round
        test_random_sets(81, 18, 80);
        // neither end idles
        test_random_sets(0, 0, 50);
        test_store_full();
        test_output_backpressure();

        wait_for_all_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
